[src/tlfb_pkg.sv]
// Shared types and constants for the tiled LED framebuffer pixel access block.
package tlfb_pkg;

   // Field and register widths fixed by the item and register layout.
   localparam int COLUMN_W = 8;
   localparam int ROW_W = 7;
   localparam int COUNT_W = 4;
   localparam int CMP_W = COUNT_W + 1;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Largest module block in bytes (24 columns, two bytes per column).
   localparam int MODULE_BYTES_MAX = 48;

   // Request kinds.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Display geometry codes.
   localparam logic MODE_32X8 = 1'b0;
   localparam logic MODE_24X16 = 1'b1;

   // Register indexes, taken from the word address.
   localparam logic [1:0] REG_DISPLAY_MODE = 2'd0;
   localparam logic [1:0] REG_MODULES_ACROSS = 2'd1;
   localparam logic [1:0] REG_MODULES_DOWN = 2'd2;

   // Live configuration.
   typedef struct packed {
      logic display_mode;
      logic [COUNT_W-1:0] modules_across;
      logic [COUNT_W-1:0] modules_down;
   } tlfb_cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic mem_read;
      logic commit;
      logic load_rsp;
   } tlfb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
   } tlfb_status_type;

endpackage

[src/tiled_led_framebuffer_pixel_access.sv]
// Top level of the tiled LED framebuffer pixel access block.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_type, req_column, req_row, req_pixel_value
//   rsp      out        rsp_valid/rsp_ready  rsp_pixel_out, rsp_in_range
//   csr      in         APB psel/penable     csr_paddr, csr_pwdata, csr_prdata
//
// Each item reads the framebuffer byte and then writes it back, both
// through the single port of the framebuffer memory.
// After reset a clearing pass zeroes all MAX_MODULES_ACROSS * MAX_MODULES_DOWN * 48 bytes
// of the framebuffer (3072 at the defaults), one byte a cycle.
// Configuration writes are taken during the pass; items are not.
// While an untaken result waits in the output register, the block holds its write phase.
module tiled_led_framebuffer_pixel_access #(
   parameter int MAX_MODULES_ACROSS = 8,
   parameter int MAX_MODULES_DOWN = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_type,
   input  logic [tlfb_pkg::COLUMN_W-1:0] req_column,
   input  logic [tlfb_pkg::ROW_W-1:0] req_row,
   input  logic req_pixel_value,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_pixel_out,
   output logic rsp_in_range,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [tlfb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tlfb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tlfb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import tlfb_pkg::*;

   tlfb_cfg_type cfg;
   tlfb_cmd_type cmd;
   tlfb_status_type status;

   // Configuration registers.
   tlfb_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   // Sequencing of each item.
   tlfb_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd(cmd),
      .status(status)
   );

   // Address decode, memory and result.
   tlfb_datapath #(
      .MAX_MODULES_ACROSS(MAX_MODULES_ACROSS),
      .MAX_MODULES_DOWN(MAX_MODULES_DOWN)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .cfg(cfg),
      .req_type(req_type),
      .req_column(req_column),
      .req_row(req_row),
      .req_pixel_value(req_pixel_value),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_in_range(rsp_in_range)
   );

endmodule

[src/tlfb_csr.sv]
// Configuration register bank with its APB-style access port.
module tlfb_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [tlfb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tlfb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tlfb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output tlfb_pkg::tlfb_cfg_type cfg
);
   import tlfb_pkg::*;

   logic display_mode_ff, display_mode_in;
   logic [COUNT_W-1:0] modules_across_ff, modules_across_in;
   logic [COUNT_W-1:0] modules_down_ff, modules_down_in;
   logic wr_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index = csr_paddr[3:2];

   // Register write decode; writes to unknown indexes are dropped.
   always_comb begin
      display_mode_in = display_mode_ff;
      modules_across_in = modules_across_ff;
      modules_down_in = modules_down_ff;
      if (wr_en) begin
         case (reg_index)
            REG_DISPLAY_MODE: begin
               display_mode_in = csr_pwdata[0];
            end
            REG_MODULES_ACROSS: begin
               modules_across_in = csr_pwdata[COUNT_W-1:0];
            end
            REG_MODULES_DOWN: begin
               modules_down_in = csr_pwdata[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_mode_ff <= MODE_32X8;
         modules_across_ff <= COUNT_W'(1);
         modules_down_ff <= COUNT_W'(1);
      end else begin
         display_mode_ff <= display_mode_in;
         modules_across_ff <= modules_across_in;
         modules_down_ff <= modules_down_in;
      end
   end

   // Read-back multiplexer.
   always_comb begin
      case (reg_index)
         REG_DISPLAY_MODE: csr_prdata = CSR_DATA_W'(display_mode_ff);
         REG_MODULES_ACROSS: csr_prdata = CSR_DATA_W'(modules_across_ff);
         REG_MODULES_DOWN: csr_prdata = CSR_DATA_W'(modules_down_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.display_mode = display_mode_ff;
   assign cfg.modules_across = modules_across_ff;
   assign cfg.modules_down = modules_down_ff;

endmodule

[src/tlfb_datapath.sv]
// Datapath: address decode, framebuffer memory, byte update and result register.
module tlfb_datapath #(
   parameter int MAX_MODULES_ACROSS = 8,
   parameter int MAX_MODULES_DOWN = 8
) (
   input  logic clock,
   input  logic reset,
   input  tlfb_pkg::tlfb_cmd_type cmd,
   output tlfb_pkg::tlfb_status_type status,
   input  tlfb_pkg::tlfb_cfg_type cfg,
   input  logic req_type,
   input  logic [tlfb_pkg::COLUMN_W-1:0] req_column,
   input  logic [tlfb_pkg::ROW_W-1:0] req_row,
   input  logic req_pixel_value,
   output logic rsp_pixel_out,
   output logic rsp_in_range
);
   import tlfb_pkg::*;

   localparam int DEPTH = MAX_MODULES_ACROSS * MAX_MODULES_DOWN * MODULE_BYTES_MAX;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int MIDX_W = $clog2(MAX_MODULES_ACROSS * MAX_MODULES_DOWN + 1);
   localparam int ACR_W = $clog2(MAX_MODULES_ACROSS + 1);
   localparam int DWN_W = $clog2(MAX_MODULES_DOWN + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   // Framebuffer memory and its registered read data.
   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Captured item and decoded address.
   logic req_type_ff;
   logic [COLUMN_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic val_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [2:0] bit_ff;
   logic ok_ff;
   logic rsp_pixel_ff, rsp_in_range_ff;
   logic [ADDR_W-1:0] clear_cnt_ff, clear_cnt_in;

   logic [ACR_W-1:0] across_c;
   logic [DWN_W-1:0] down_c;
   logic [3:0] mx, my;
   logic [4:0] lc;
   logic [5:0] local_byte;
   logic [MIDX_W-1:0] mod_idx;
   logic [ADDR_W-1:0] idx_ext, base, byte_addr;
   logic ok;
   logic [4:0] col_div8;
   logic [9:0] div3_prod;
   logic [7:0] mx_times24;
   logic [ADDR_W-1:0] mem_addr;
   logic mem_we;
   logic [7:0] mem_wdata, mask;

   // Module counts held to their maxima.
   always_comb begin
      if ({1'b0, cfg.modules_across} > CMP_W'(MAX_MODULES_ACROSS)) begin
         across_c = ACR_W'(MAX_MODULES_ACROSS);
      end else begin
         across_c = ACR_W'(cfg.modules_across);
      end
      if ({1'b0, cfg.modules_down} > CMP_W'(MAX_MODULES_DOWN)) begin
         down_c = DWN_W'(MAX_MODULES_DOWN);
      end else begin
         down_c = DWN_W'(cfg.modules_down);
      end
   end

   // Module column and row; a division by 24 is a division of col/8 by 3,
   // done as a multiplication by 11/32, exact for values below 32.
   assign col_div8 = col_ff[7:3];
   assign div3_prod = 10'(col_div8) * 10'd11;
   assign mx_times24 = 8'({mx, 4'b0000}) + 8'({mx, 3'b000});

   always_comb begin
      if (cfg.display_mode == MODE_24X16) begin
         mx = div3_prod[8:5];
         my = {1'b0, row_ff[6:4]};
         lc = 5'(col_ff - mx_times24);
         local_byte = {lc, row_ff[3]};
      end else begin
         mx = {1'b0, col_ff[7:5]};
         my = row_ff[6:3];
         lc = col_ff[4:0];
         local_byte = {1'b0, lc};
      end
   end

   // Range check and byte address of the pixel.
   assign ok = (CMP_W'(mx) < CMP_W'(across_c)) && (CMP_W'(my) < CMP_W'(down_c));
   assign mod_idx = MIDX_W'(MIDX_W'(my) * MIDX_W'(across_c) + MIDX_W'(mx));
   assign idx_ext = ADDR_W'(mod_idx);
   assign base = (idx_ext << 5) +
                 ((cfg.display_mode == MODE_24X16) ? (idx_ext << 4) : '0);
   assign byte_addr = ok ? (base + ADDR_W'(local_byte)) : '0;

   // Single memory port: clearing pass, read phase or write phase.
   assign mask = 8'b0000_0001 << bit_ff;
   assign mem_addr = cmd.clear_step ? clear_cnt_ff : (cmd.mem_read ? byte_addr : addr_ff);
   assign mem_we = cmd.clear_step || (cmd.commit && ok_ff && (req_type_ff == REQ_WRITE));
   always_comb begin
      if (cmd.clear_step) begin
         mem_wdata = '0;
      end else if (val_ff) begin
         mem_wdata = rd_data_ff | mask;
      end else begin
         mem_wdata = rd_data_ff & ~mask;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= store_ff[mem_addr];
      end
   end

   // Clearing pass counter.
   assign clear_cnt_in = cmd.clear_step ? clear_cnt_ff + ADDR_W'(1) : clear_cnt_ff;
   assign status.clear_last = (clear_cnt_ff == LAST_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // Item capture, decoded address and result registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_type_ff <= req_type;
         col_ff <= req_column;
         row_ff <= req_row;
         val_ff <= req_pixel_value;
      end
      if (cmd.mem_read) begin
         addr_ff <= byte_addr;
         bit_ff <= row_ff[2:0];
         ok_ff <= ok;
      end
      if (cmd.load_rsp) begin
         rsp_pixel_ff <= ok_ff && (req_type_ff == REQ_READ) && rd_data_ff[bit_ff];
         rsp_in_range_ff <= ok_ff;
      end
   end

   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_in_range = rsp_in_range_ff;

endmodule

[src/tlfb_ctrl.sv]
// Controller: clearing pass, read and write phases, and the result handshake.
module tlfb_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output tlfb_pkg::tlfb_cmd_type cmd,
   input  tlfb_pkg::tlfb_status_type status
);
   import tlfb_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free, accept;

   // The result register can take a new item when empty or being emptied.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_WRITE) && slot_free);
   assign accept = req_valid && req_ready;

   // Commands to the datapath.
   assign cmd.clear_step = (state_ff == ST_CLEAR);
   assign cmd.load_req = accept;
   assign cmd.mem_read = (state_ff == ST_READ);
   assign cmd.commit = (state_ff == ST_WRITE);
   assign cmd.load_rsp = (state_ff == ST_WRITE) && slot_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (slot_free) begin
               state_in = accept ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // No item is taken while the framebuffer is being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("item accepted during clearing pass");

   // An accepted item always goes to the read phase.
   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_READ))
      else $error("accepted item did not enter read phase");

   // The read phase is always followed by the write phase.
   a_read_to_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_WRITE))
      else $error("read phase not followed by write phase");

   // A new result only appears out of the write phase.
   a_result_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WRITE))
      else $error("result raised outside write phase");

endmodule
